// ----- rtl/b64lw_pkg.sv -----
// Package for the line-wrapped base64 encoder: group job type, step codes,
// character constants and the base64 symbol function.
// No dependencies.
`timescale 1ns / 1ps

package b64lw_pkg;

  localparam logic [6:0] LINE_LIMIT   = 7'd100;
  localparam logic [6:0] PAD_CHAR     = 7'd61;
  localparam logic [6:0] NEWLINE_CHAR = 7'd10;
  localparam logic [6:0] COL_STEP     = 7'd4;

  // Positions within the character sequence of one group.
  localparam logic [2:0] STEP_NL_FIRST = 3'd0;
  localparam logic [2:0] STEP_SYM0     = 3'd1;
  localparam logic [2:0] STEP_SYM1     = 3'd2;
  localparam logic [2:0] STEP_SYM2     = 3'd3;
  localparam logic [2:0] STEP_SYM3     = 3'd4;
  localparam logic [2:0] STEP_NL_LAST  = 3'd5;

  // Byte counts of a group.
  localparam logic [1:0] NBYTES_ONE   = 2'd1;
  localparam logic [1:0] NBYTES_TWO   = 2'd2;
  localparam logic [1:0] NBYTES_THREE = 2'd3;

  // One group handed from the front to the back.
  typedef struct packed {
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] b2;
    logic [1:0] nbytes;
    logic       nl_first;
    logic       fin;
  } b64lw_job_t;

  // Map a six-bit value to its base64 alphabet character.
  function automatic logic [6:0] b64_sym(input logic [5:0] v);
    logic [6:0] v7;
    v7 = {1'b0, v};
    if (v < 6'd26) begin
      return 7'd65 + v7;
    end else if (v < 6'd52) begin
      return 7'd71 + v7;          // 'a' - 26
    end else if (v < 6'd62) begin
      return v7 - 7'd4;           // '0' - 52
    end else if (v == 6'd62) begin
      return 7'd43;               // '+'
    end else begin
      return 7'd47;               // '/'
    end
  endfunction

endpackage

// ----- rtl/b64lw_front.sv -----
// Front end of the encoder: accepts payload bytes, gathers groups of three
// and tracks the line column. Depends on b64lw_pkg.
`timescale 1ns / 1ps

module b64lw_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic [7:0]          data_byte,
  input  logic                final_byte,
  input  logic                q_full,
  output logic                q_push,
  output b64lw_pkg::b64lw_job_t q_job
);
  import b64lw_pkg::*;

  logic [15:0] held_bytes, held_bytes_next;
  logic [1:0]  group_phase, group_phase_next;
  logic [6:0]  line_column, line_column_next;
  logic [1:0]  phase;
  logic        accept;
  logic        emit;
  b64lw_job_t  job;

  assign accept = in_valid && !q_full;
  // A stray phase of three is treated as an empty group.
  assign phase  = (group_phase == 2'd3) ? 2'd0 : group_phase;

  // Build the group that this byte would complete.
  always_comb begin
    job.nbytes = phase + 2'd1;
    job.fin    = final_byte;
    unique case (phase)
      2'd0: begin
        job.b0 = data_byte;
        job.b1 = 8'd0;
        job.b2 = 8'd0;
      end
      2'd1: begin
        job.b0 = held_bytes[15:8];
        job.b1 = data_byte;
        job.b2 = 8'd0;
      end
      default: begin
        job.b0 = held_bytes[15:8];
        job.b1 = held_bytes[7:0];
        job.b2 = data_byte;
      end
    endcase
    job.nl_first = (line_column >= LINE_LIMIT);
  end

  assign emit   = final_byte || (job.nbytes == NBYTES_THREE);
  assign q_push = accept && emit;
  assign q_job  = job;

  // Next values of the grouping and column state.
  always_comb begin
    held_bytes_next  = held_bytes;
    group_phase_next = group_phase;
    line_column_next = line_column;
    if (accept) begin
      if (!emit) begin
        held_bytes_next  = {job.b0, job.b1};
        group_phase_next = job.nbytes;
      end else begin
        held_bytes_next  = 16'd0;
        group_phase_next = 2'd0;
        if (job.nl_first) begin
          line_column_next = 7'd0;
        end
        if (job.nbytes == NBYTES_THREE) begin
          line_column_next = line_column_next + COL_STEP;
        end
        if (final_byte) begin
          line_column_next = 7'd0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_bytes  <= 16'd0;
      group_phase <= 2'd0;
      line_column <= 7'd0;
    end else begin
      held_bytes  <= held_bytes_next;
      group_phase <= group_phase_next;
      line_column <= line_column_next;
    end
  end

endmodule

// ----- rtl/b64lw_cmdq.sv -----
// Two-entry queue of group jobs between the front and the back.
// Depends on b64lw_pkg.
`timescale 1ns / 1ps

module b64lw_cmdq (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  b64lw_pkg::b64lw_job_t push_job,
  input  logic                  pop,
  output logic                  q_full,
  output logic                  q_empty,
  output b64lw_pkg::b64lw_job_t head_job
);
  import b64lw_pkg::*;

  b64lw_job_t entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       do_push;
  logic       do_pop;

  assign q_full   = (count == 2'd2);
  assign q_empty  = (count == 2'd0);
  assign do_push  = push && !q_full;
  assign do_pop   = pop && !q_empty;
  assign head_job = entries[rd_ptr];

  // Entry storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_job;
    end
  end

  // Pointers and occupancy.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (do_push && !do_pop) begin
        count <= count + 2'd1;
      end else if (do_pop && !do_push) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule

// ----- rtl/b64lw_back.sv -----
// Back end of the encoder: steps the queued group's characters into the result
// register, one per cycle while the receiver keeps up. Depends on b64lw_pkg.
`timescale 1ns / 1ps

module b64lw_back (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  q_empty,
  input  b64lw_pkg::b64lw_job_t head_job,
  output logic                  q_pop,
  input  logic                  pop,
  output logic                  empty,
  output logic [6:0]            out_char,
  output logic                  run_end
);
  import b64lw_pkg::*;

  logic [2:0] step, step_next;
  logic [2:0] cur_step;
  logic       last;
  logic       emit;
  logic       out_valid;
  logic [6:0] char_val;

  // Skip the leading newline when the line still has room.
  assign cur_step = (step == STEP_NL_FIRST && !head_job.nl_first) ? STEP_SYM0 : step;
  assign last     = head_job.fin ? (cur_step == STEP_NL_LAST) : (cur_step == STEP_SYM3);
  assign emit     = !q_empty && (!out_valid || pop);
  assign q_pop    = emit && last;
  assign empty    = !out_valid;

  // Character for the current step.
  always_comb begin
    unique case (cur_step)
      STEP_SYM0: char_val = b64_sym(head_job.b0[7:2]);
      STEP_SYM1: char_val = b64_sym({head_job.b0[1:0], head_job.b1[7:4]});
      STEP_SYM2: begin
        char_val = (head_job.nbytes == NBYTES_ONE) ? PAD_CHAR
                 : b64_sym({head_job.b1[3:0], head_job.b2[7:6]});
      end
      STEP_SYM3: begin
        char_val = (head_job.nbytes == NBYTES_THREE) ? b64_sym(head_job.b2[5:0])
                 : PAD_CHAR;
      end
      default:   char_val = NEWLINE_CHAR;
    endcase
  end

  assign step_next = last ? STEP_NL_FIRST : (cur_step + 3'd1);

  // Step counter and result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      step      <= STEP_NL_FIRST;
      out_valid <= 1'b0;
    end else begin
      if (emit) begin
        step      <= step_next;
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_char <= char_val;
      run_end  <= last;
    end
  end

endmodule

// ----- rtl/base64_line_wrapped_encoder.sv -----
// Base64 encoder with 100-character line wrapping and '=' padding.
// Takes one payload byte per beat and gives ASCII characters one per beat.
// Input: push with data_byte and final_byte; a beat is taken when push is
// high and full is low. final_byte marks the last byte of a payload.
// Output: while empty is low, out_char and run_end show the oldest character;
// it is taken when pop is high and empty is low. run_end marks the last
// character caused by an input byte.
// A byte that completes a group, or a final byte, puts its job into the queue
// at the edge that takes it; the result register then loads the first
// character from the queue head. Bytes that only fill a group give none.
// Throughput: the back end emits one character per cycle while the receiver
// keeps up, so the character sequencer sets the sustained rate. Each group
// gives four characters, plus a leading newline when the line is full and a
// closing newline after a final byte. A two-entry job queue lets the front
// keep taking bytes meanwhile.
// When the receiver stalls, the result register holds, the queue fills and
// full rises. Reset clears the held group, the column count, the queue and
// the result register; the block is ready on the cycle after reset.
// Depends on b64lw_pkg, b64lw_front, b64lw_cmdq and b64lw_back.
`timescale 1ns / 1ps

module base64_line_wrapped_encoder (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  logic [7:0] data_byte,
  input  logic       final_byte,
  output logic       empty,
  input  logic       pop,
  output logic [6:0] out_char,
  output logic       run_end
);
  import b64lw_pkg::*;

  b64lw_job_t push_job;
  b64lw_job_t head_job;
  logic       q_push;
  logic       q_pop;
  logic       q_full;
  logic       q_empty;

  assign full = q_full;

  // Byte gathering and column tracking.
  b64lw_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (push),
    .data_byte  (data_byte),
    .final_byte (final_byte),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_job      (push_job)
  );

  // Job queue between the two halves.
  b64lw_cmdq u_cmdq (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_job (push_job),
    .pop      (q_pop),
    .q_full   (q_full),
    .q_empty  (q_empty),
    .head_job (head_job)
  );

  // Character sequencer and result register.
  b64lw_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_empty  (q_empty),
    .head_job (head_job),
    .q_pop    (q_pop),
    .pop      (pop),
    .empty    (empty),
    .out_char (out_char),
    .run_end  (run_end)
  );

endmodule

// ----- tb/b64lw_checker.sv -----
// Checker for the line-wrapped base64 encoder: watches the byte and character
// channels, predicts the character stream and compares each beat field by field.
// Depends on b64lw_pkg for the character constants.
`timescale 1ns / 1ps

module b64lw_checker (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  logic       full,
  input  logic [7:0] data_byte,
  input  logic       final_byte,
  input  logic       empty,
  input  logic       pop,
  input  logic [6:0] out_char,
  input  logic       run_end,
  output int         fail_count,
  output int         chars_pending
);
  import b64lw_pkg::*;

  typedef struct packed {
    logic [6:0] ch;
    logic       last;
  } char_beat_t;

  // Symbol table, first symbol in the top byte.
  localparam logic [8*64-1:0] SYMBOLS =
    "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

  char_beat_t  expected_chars[$];
  logic [15:0] held_bytes;
  logic [1:0]  group_phase;
  logic [6:0]  line_column;

  initial begin
    fail_count    = 0;
    chars_pending = 0;
  end

  function automatic logic [6:0] symbol_of(input logic [5:0] six);
    int pos;
    pos = 8 * (63 - int'(six));
    return SYMBOLS[pos +: 7];
  endfunction

  // One line per mismatch, and the count goes up.
  task automatic report_mismatch(input string msg);
    fail_count++;
    $display("%0t ns mismatch: %s", $time, msg);
  endtask

  // Work out the characters one accepted byte causes and queue them.
  task automatic encode_beat(input logic [7:0] b, input logic fin);
    logic [7:0] b0, b1, b2;
    logic [1:0] nbytes;
    logic [6:0] chars [6];
    int         n;
    n  = 0;
    b0 = held_bytes[15:8];
    b1 = held_bytes[7:0];
    b2 = 8'h00;
    case (group_phase)
      2'd1:    b1 = b;
      2'd2:    b2 = b;
      default: begin
        b0 = b;
        b1 = 8'h00;
      end
    endcase
    nbytes = (group_phase == 2'd3) ? 2'd1 : group_phase + 2'd1;

    // A group that is still short and not final is only held.
    if (nbytes != 2'd3 && !fin) begin
      held_bytes  = {b0, b1};
      group_phase = nbytes;
      return;
    end

    // A full line is closed before the next group goes out.
    if (line_column >= LINE_LIMIT) begin
      chars[n] = NEWLINE_CHAR;
      n++;
      line_column = 7'd0;
    end
    chars[n] = symbol_of(b0[7:2]);
    n++;
    chars[n] = symbol_of({b0[1:0], b1[7:4]});
    n++;
    if (nbytes == 2'd1) begin
      chars[n] = PAD_CHAR;
      n++;
      chars[n] = PAD_CHAR;
      n++;
    end else begin
      chars[n] = symbol_of({b1[3:0], b2[7:6]});
      n++;
      if (nbytes == 2'd2) begin
        chars[n] = PAD_CHAR;
        n++;
      end else begin
        chars[n] = symbol_of(b2[5:0]);
        n++;
        line_column = line_column + 7'd4;
      end
    end
    held_bytes  = 16'h0000;
    group_phase = 2'd0;

    // The end of a payload closes the line and starts afresh.
    if (fin) begin
      chars[n] = NEWLINE_CHAR;
      n++;
      line_column = 7'd0;
    end
    for (int i = 0; i < n; i++) begin
      expected_chars.push_back('{ch: chars[i], last: (i == n - 1)});
    end
  endtask

  // Compare the character beat first, then predict from the byte beat.
  always @(posedge clk) begin
    char_beat_t want;
    if (rst) begin
      held_bytes  = 16'h0000;
      group_phase = 2'd0;
      line_column = 7'd0;
      expected_chars.delete();
    end else begin
      if (pop && !empty) begin
        if (expected_chars.size() == 0) begin
          report_mismatch($sformatf("unexpected character %0d run_end %0b",
                                    out_char, run_end));
        end else begin
          want = expected_chars.pop_front();
          if (out_char !== want.ch) begin
            report_mismatch($sformatf("out_char %0d, predicted %0d",
                                      out_char, want.ch));
          end
          if (run_end !== want.last) begin
            report_mismatch($sformatf("run_end %0b, predicted %0b on char %0d",
                                      run_end, want.last, want.ch));
          end
        end
      end
      if (push && !full) begin
        encode_beat(data_byte, final_byte);
      end
    end
    chars_pending = expected_chars.size();
  end

endmodule

// ----- tb/tb_base64_line_wrapped_encoder.sv -----
// Testbench top for the line-wrapped base64 encoder: drives payload bytes and
// character pops with random idling, and gives the verdict.
// Depends on base64_line_wrapped_encoder and b64lw_checker.
`timescale 1ns / 1ps

module tb_base64_line_wrapped_encoder;

  typedef struct packed {
    logic [7:0] data;
    logic       fin;
  } payload_byte_t;

  logic       clk;
  logic       rst;
  logic       push;
  logic       full;
  logic [7:0] data_byte;
  logic       final_byte;
  logic       empty;
  logic       pop;
  logic [6:0] out_char;
  logic       run_end;
  int         fail_count;
  int         chars_pending;

  payload_byte_t byte_plan[$];
  int            bytes_sent;
  bit            quiet;
  bit            stall_done;

  base64_line_wrapped_encoder u_top (.*);

  b64lw_checker u_checker (.*);

  // Clock.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard limit on the run.
  initial begin
    #2_000_000;
    $display("== FAIL ==");
    $finish;
  end

  task automatic plan_byte(input logic [7:0] b, input logic fin);
    byte_plan.push_back('{data: b, fin: fin});
  endtask

  task automatic plan_payload(input int len);
    for (int i = 0; i < len; i++) begin
      plan_byte(8'($urandom_range(0, 255)), i == len - 1);
    end
  endtask

  // Offer one byte, maybe after an idle burst, and hold it until it is taken.
  task automatic send_byte(input logic [7:0] b, input logic fin);
    int gap;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 9);
      push <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    push       <= 1'b1;
    data_byte  <= b;
    final_byte <= fin;
    @(posedge clk);
    while (full) @(posedge clk);
    bytes_sent++;
    @(negedge clk);
  endtask

  // Receiver side: random pop bursts, plus one long hold-off that fills the block.
  initial begin
    int gap;
    pop = 1'b0;
    while (rst !== 1'b0) @(negedge clk);
    forever begin
      @(negedge clk);
      if (!stall_done && bytes_sent >= 40) begin
        stall_done = 1'b1;
        pop <= 1'b0;
        repeat (80) @(negedge clk);
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        gap = $urandom_range(1, 9);
        pop <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end else begin
        pop <= 1'b1;
      end
    end
  end

  // Sender side and verdict.
  initial begin
    payload_byte_t pb;
    int            random_items;
    bit            long_done;
    int            len;
    rst        = 1'b1;
    push       = 1'b0;
    data_byte  = 8'h00;
    final_byte = 1'b0;
    bytes_sent = 0;
    quiet      = 1'b0;
    stall_done = 1'b0;

    // Directed payloads: single bytes at both extremes, both two-byte
    // orders, complete groups of zeros and ones, and mixed longer tails.
    plan_byte(8'h00, 1'b1);
    plan_byte(8'hFF, 1'b1);
    plan_byte(8'hFF, 1'b0); plan_byte(8'h00, 1'b1);
    plan_byte(8'h00, 1'b0); plan_byte(8'hFF, 1'b1);
    plan_byte(8'hFF, 1'b0); plan_byte(8'hFF, 1'b0); plan_byte(8'hFF, 1'b1);
    plan_byte(8'h00, 1'b0); plan_byte(8'h00, 1'b0); plan_byte(8'h00, 1'b1);
    plan_byte(8'hF0, 1'b0); plan_byte(8'h0F, 1'b0); plan_byte(8'hC3, 1'b0);
    plan_byte(8'h3C, 1'b0); plan_byte(8'hA5, 1'b1);
    plan_byte(8'h5A, 1'b0); plan_byte(8'hA5, 1'b0); plan_byte(8'h01, 1'b0);
    plan_byte(8'h80, 1'b1);

    // Random payloads: mostly short, one long enough to wrap the line twice.
    random_items = 0;
    long_done    = 1'b0;
    while (random_items < 190) begin
      if (!long_done && random_items >= 10) begin
        len       = $urandom_range(155, 170);
        long_done = 1'b1;
      end else begin
        len = $urandom_range(1, 12);
      end
      plan_payload(len);
      random_items += len;
    end

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    while (byte_plan.size() != 0) begin
      quiet = (byte_plan.size() <= 30);
      pb = byte_plan.pop_front();
      send_byte(pb.data, pb.fin);
    end
    push <= 1'b0;

    // Drain, then give the block time to show any stray character.
    while (chars_pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fail_count == 0 && chars_pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/b64lw_pkg.sv
rtl/b64lw_front.sv
rtl/b64lw_cmdq.sv
rtl/b64lw_back.sv
rtl/base64_line_wrapped_encoder.sv
tb/b64lw_checker.sv
tb/tb_base64_line_wrapped_encoder.sv
